### sv/pac3d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pac3d_pkg;

  localparam int CoordW   = 32;
  localparam int FracB    = 16;
  localparam int NormW    = 16;
  localparam int AccW     = 64;
  localparam int TriShift = 2 * FracB + (NormW - 2) + 1 - 32;
  localparam int DiffW    = CoordW + 1;
  localparam int SumW     = CoordW + 2;
  localparam int ProdW    = 2 * DiffW;
  localparam int CrossW   = ProdW + 1;
  localparam int TermW    = CrossW + NormW;
  localparam int DotW     = TermW + 2;
  localparam int LoW      = 33 + SumW;
  localparam int HiW      = 32 + SumW;
  localparam int WtW      = HiW + 1;
  localparam int SatInW   = DotW;
  localparam int DivShift = 32;
  localparam int DivNW    = AccW + DivShift;
  localparam int DivDW    = AccW + 2;
  localparam int DivCntW  = $clog2(DivNW);
  localparam int CtrSW    = DivNW + 2;
  localparam int CntW     = 2;
  localparam int AxisW    = 2;

  localparam logic [CntW-1:0]    CntFull  = 2'd3;
  localparam logic [AxisW-1:0]   AxisLast = 2'd2;
  localparam logic [DivCntW-1:0] DivLast  = DivCntW'(DivNW - 1);

  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW - 1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW - 1){1'b0}}};
  localparam logic signed [CoordW-1:0] CoordMax = {1'b0, {(CoordW - 1){1'b1}}};
  localparam logic signed [CoordW-1:0] CoordMin = {1'b1, {(CoordW - 1){1'b0}}};

  typedef logic signed [CoordW-1:0] coord_t;
  typedef logic signed [NormW-1:0]  norm_t;
  typedef logic signed [AccW-1:0]   acc_t;

  typedef struct packed {
    logic accept;
    logic diff;
    logic mul1;
    logic mul2;
    logic dot;
    logic area;
    logic wmul;
    logic wacc;
    logic fin;
    logic div_step;
    logic load_out;
  } pac3d_cmd_t;

  typedef struct packed {
    logic start;
    logic fan;
    logic last_in;
    logic last_q;
    logic want_q;
    logic ctr_valid;
    logic div_done;
    logic last_axis;
    logic out_free;
  } pac3d_sts_t;

endpackage

`default_nettype wire

### sv/pac3d_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pac3d_vtx_if;
  logic                   valid;
  logic                   ready;
  pac3d_pkg::coord_t      vertex_x;
  pac3d_pkg::coord_t      vertex_y;
  pac3d_pkg::coord_t      vertex_z;
  pac3d_pkg::norm_t       normal_x;
  pac3d_pkg::norm_t       normal_y;
  pac3d_pkg::norm_t       normal_z;
  logic                   want_center;
  logic                   first_vertex;
  logic                   last_vertex;

  modport source (output valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
                  want_center, first_vertex, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, vertex_z, normal_x, normal_y, normal_z,
                  want_center, first_vertex, last_vertex, output ready);
endinterface

interface pac3d_res_if;
  logic              valid;
  logic              ready;
  pac3d_pkg::acc_t   area;
  pac3d_pkg::coord_t center_x;
  pac3d_pkg::coord_t center_y;
  pac3d_pkg::coord_t center_z;
  logic              center_valid;
  logic              too_few_vertices;
  logic              saturated;

  modport source (output valid, area, center_x, center_y, center_z, center_valid,
                  too_few_vertices, saturated, input ready);
  modport sink   (input valid, area, center_x, center_y, center_z, center_valid,
                  too_few_vertices, saturated, output ready);
endinterface

`default_nettype wire

### sv/polygon_area_centroid_3d.sv
`timescale 1ns / 1ps
`default_nettype none

// Port     Dir  Word
// vtx_i    in   one polygon vertex, normal and flags
// res_o    out  area, centroid and flags, one per last vertex
//
// A vertex that closes a fan triangle steps through diff, mul1, mul2, dot and area (three
// 33x33 and 67x16 multiplier lanes), plus wmul and wacc with a centroid; others are only
// accepted. A last vertex then runs fin, the bit-serial divider for a centroid, and res.
// Reset is asynchronous and clears the controller, vertex count and output valid.
// Input stalls while a vertex or result is in flight; results wait in the output register.

module polygon_area_centroid_3d (
  input  logic        clk_i,
  input  logic        rst_ni,
  pac3d_vtx_if.sink   vtx_i,
  pac3d_res_if.source res_o
);

  pac3d_pkg::pac3d_cmd_t cmd;
  pac3d_pkg::pac3d_sts_t sts;
  logic                  in_ready;

  assign vtx_i.ready = in_ready;

  pac3d_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (vtx_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pac3d_dp u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  a_ctr_needs_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.center_valid |-> !res_o.too_few_vertices)
    else $error("centroid flagged on a degenerate polygon");

  a_few_zero_area: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.too_few_vertices |-> res_o.area == '0)
    else $error("nonzero area with too few vertices");

  a_ctr_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && !res_o.center_valid |->
      res_o.center_x == '0 && res_o.center_y == '0 && res_o.center_z == '0)
    else $error("centroid not cleared");

endmodule

`default_nettype wire

### sv/pac3d_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module pac3d_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  pac3d_pkg::pac3d_sts_t sts_i,
  output pac3d_pkg::pac3d_cmd_t cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIFF, S_MUL1, S_MUL2, S_DOT, S_AREA, S_WMUL, S_WACC, S_FIN, S_DIV, S_RES
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          if (sts_i.fan) begin
            state_d = S_DIFF;
          end else if (sts_i.last_in) begin
            state_d = S_FIN;
          end
        end
      end
      S_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = S_MUL1;
      end
      S_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = S_MUL2;
      end
      S_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = S_DOT;
      end
      S_DOT: begin
        cmd_o.dot = 1'b1;
        state_d   = S_AREA;
      end
      S_AREA: begin
        cmd_o.area = 1'b1;
        if (sts_i.want_q) begin
          state_d = S_WMUL;
        end else begin
          state_d = sts_i.last_q ? S_FIN : S_IDLE;
        end
      end
      S_WMUL: begin
        cmd_o.wmul = 1'b1;
        state_d    = S_WACC;
      end
      S_WACC: begin
        cmd_o.wacc = 1'b1;
        state_d    = sts_i.last_q ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd_o.fin = 1'b1;
        state_d   = sts_i.ctr_valid ? S_DIV : S_RES;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done && sts_i.last_axis) begin
          state_d = S_RES;
        end
      end
      S_RES: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### sv/pac3d_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module pac3d_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  pac3d_vtx_if.sink             vtx_i,
  pac3d_res_if.source           res_o,
  input  pac3d_pkg::pac3d_cmd_t cmd_i,
  output pac3d_pkg::pac3d_sts_t sts_o
);

  // {clip, value}
  function automatic logic [pac3d_pkg::AccW:0] sat_acc(
    input logic signed [pac3d_pkg::SatInW-1:0] v
  );
    logic ok;
    ok = (v[pac3d_pkg::SatInW-1:pac3d_pkg::AccW-1] ==
          {(pac3d_pkg::SatInW - pac3d_pkg::AccW + 1){v[pac3d_pkg::AccW-1]}});
    if (ok) begin
      return {1'b0, v[pac3d_pkg::AccW-1:0]};
    end
    return {1'b1, (v[pac3d_pkg::SatInW-1] ? pac3d_pkg::AccMin : pac3d_pkg::AccMax)};
  endfunction

  function automatic logic [pac3d_pkg::AccW-1:0] mag(input pac3d_pkg::acc_t v);
    return v[pac3d_pkg::AccW-1] ? -v : v;
  endfunction

  pac3d_pkg::coord_t vin [3];
  pac3d_pkg::norm_t  nin [3];

  pac3d_pkg::coord_t anchor_q [3];
  pac3d_pkg::coord_t prev_q [3];
  pac3d_pkg::coord_t cur_q [3];
  pac3d_pkg::norm_t  norm_q [3];
  pac3d_pkg::acc_t   wsum_q [3];
  pac3d_pkg::acc_t   area_q;
  pac3d_pkg::acc_t   at_q;
  logic              want_q, last_q, sat_q, fclip_q;
  logic [pac3d_pkg::CntW-1:0] cnt_q;

  logic signed [pac3d_pkg::DiffW-1:0]  a1_q [3];
  logic signed [pac3d_pkg::DiffW-1:0]  a2_q [3];
  logic signed [pac3d_pkg::SumW-1:0]   d_q [3];
  logic signed [pac3d_pkg::ProdW-1:0]  p_q [3];
  logic signed [pac3d_pkg::CrossW-1:0] c_q [3];
  logic signed [pac3d_pkg::TermW-1:0]  m_q [3];
  logic signed [pac3d_pkg::LoW-1:0]    lo_q [3];
  logic signed [pac3d_pkg::HiW-1:0]    hi_q [3];

  logic [pac3d_pkg::AxisW-1:0]   axis_q;
  logic [pac3d_pkg::DivCntW-1:0] bit_q;
  logic [pac3d_pkg::DivDW-1:0]   dvs_q;
  logic [pac3d_pkg::DivDW-1:0]   rem_q;
  logic [pac3d_pkg::DivNW-1:0]   num_q;
  pac3d_pkg::coord_t             ctr_q [3];
  logic                          out_valid_q;

  logic signed [pac3d_pkg::DotW-1:0] dot_sum, dot_sh;
  logic [pac3d_pkg::AccW:0]          at_sat, area_sat;
  logic [pac3d_pkg::AccW:0]          ws_sat [3];
  logic signed [pac3d_pkg::WtW-1:0]  wt [3];
  logic [pac3d_pkg::DivDW:0]         r2;
  logic                              ge;
  logic [pac3d_pkg::DivDW-1:0]       rem_d;
  logic [pac3d_pkg::DivNW-1:0]       num_d;
  logic [pac3d_pkg::AccW-1:0]        abs_a, w_next_abs;
  logic                              neg_q;
  logic signed [pac3d_pkg::CtrSW-1:0] qs, csum;
  logic                              c_ok;
  pac3d_pkg::coord_t                 c_clamp;
  pac3d_pkg::acc_t                   w_next;

  always_comb begin
    vin[0] = vtx_i.vertex_x;
    vin[1] = vtx_i.vertex_y;
    vin[2] = vtx_i.vertex_z;
    nin[0] = vtx_i.normal_x;
    nin[1] = vtx_i.normal_y;
    nin[2] = vtx_i.normal_z;
  end

  assign sts_o.start     = vtx_i.first_vertex | (cnt_q == '0);
  assign sts_o.fan       = !sts_o.start & cnt_q[1];
  assign sts_o.last_in   = vtx_i.last_vertex;
  assign sts_o.last_q    = last_q;
  assign sts_o.want_q    = want_q;
  assign sts_o.ctr_valid = want_q & (cnt_q == pac3d_pkg::CntFull) & (area_q != '0);
  assign sts_o.div_done  = (bit_q == pac3d_pkg::DivLast);
  assign sts_o.last_axis = (axis_q == pac3d_pkg::AxisLast);
  assign sts_o.out_free  = !out_valid_q | res_o.ready;

  // triangle area and running sums
  always_comb begin
    dot_sum = pac3d_pkg::DotW'(m_q[0]) + pac3d_pkg::DotW'(m_q[1]) + pac3d_pkg::DotW'(m_q[2]);
    dot_sh  = dot_sum >>> pac3d_pkg::TriShift;
    at_sat  = sat_acc(pac3d_pkg::SatInW'(dot_sh));
    area_sat = sat_acc(pac3d_pkg::SatInW'(area_q) +
                       pac3d_pkg::SatInW'($signed(at_sat[pac3d_pkg::AccW-1:0])));
    for (int i = 0; i < 3; i++) begin
      wt[i] = pac3d_pkg::WtW'(hi_q[i]) + pac3d_pkg::WtW'(lo_q[i] >>> 32);
      ws_sat[i] = sat_acc(pac3d_pkg::SatInW'(wsum_q[i]) + pac3d_pkg::SatInW'(wt[i]));
    end
  end

  // restoring divide, one quotient bit per cycle
  always_comb begin
    r2    = {rem_q, num_q[pac3d_pkg::DivNW-1]};
    ge    = (r2 >= {1'b0, dvs_q});
    rem_d = ge ? pac3d_pkg::DivDW'(r2 - {1'b0, dvs_q}) : r2[pac3d_pkg::DivDW-1:0];
    num_d = {num_q[pac3d_pkg::DivNW-2:0], ge};
    abs_a = mag(area_q);
    neg_q = wsum_q[axis_q][pac3d_pkg::AccW-1] ^ area_q[pac3d_pkg::AccW-1];
    qs    = $signed({2'b00, num_d});
    csum  = pac3d_pkg::CtrSW'(anchor_q[axis_q]) + (neg_q ? -qs : qs);
    c_ok  = (csum[pac3d_pkg::CtrSW-1:pac3d_pkg::CoordW-1] ==
             {(pac3d_pkg::CtrSW - pac3d_pkg::CoordW + 1){csum[pac3d_pkg::CoordW-1]}});
    c_clamp = c_ok ? csum[pac3d_pkg::CoordW-1:0] :
              (csum[pac3d_pkg::CtrSW-1] ? pac3d_pkg::CoordMin : pac3d_pkg::CoordMax);
    case (axis_q)
      2'd0:    w_next = wsum_q[1];
      default: w_next = wsum_q[2];
    endcase
    w_next_abs = mag(w_next);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        if (sts_o.start) begin
          cnt_q <= 2'd1;
        end else if (cnt_q != pac3d_pkg::CntFull) begin
          cnt_q <= cnt_q + 2'd1;
        end
      end
      if (cmd_i.load_out) begin
        cnt_q       <= '0;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      last_q <= vtx_i.last_vertex;
      for (int i = 0; i < 3; i++) begin
        cur_q[i] <= vin[i];
        if (!sts_o.fan) begin
          prev_q[i] <= vin[i];
        end
      end
      if (sts_o.start) begin
        want_q <= vtx_i.want_center;
        area_q <= '0;
        sat_q  <= 1'b0;
        for (int i = 0; i < 3; i++) begin
          anchor_q[i] <= vin[i];
          norm_q[i]   <= nin[i];
          wsum_q[i]   <= '0;
        end
      end
    end
    if (cmd_i.diff) begin
      for (int i = 0; i < 3; i++) begin
        a1_q[i]   <= pac3d_pkg::DiffW'(prev_q[i]) - pac3d_pkg::DiffW'(anchor_q[i]);
        a2_q[i]   <= pac3d_pkg::DiffW'(cur_q[i]) - pac3d_pkg::DiffW'(anchor_q[i]);
        d_q[i]    <= pac3d_pkg::SumW'(prev_q[i]) + pac3d_pkg::SumW'(cur_q[i])
                     - pac3d_pkg::SumW'(anchor_q[i]) - pac3d_pkg::SumW'(anchor_q[i]);
        prev_q[i] <= cur_q[i];
      end
    end
    if (cmd_i.mul1) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= a1_q[(i + 1) % 3] * a2_q[(i + 2) % 3];
      end
    end
    if (cmd_i.mul2) begin
      for (int i = 0; i < 3; i++) begin
        c_q[i] <= p_q[i] - (a1_q[(i + 2) % 3] * a2_q[(i + 1) % 3]);
      end
    end
    if (cmd_i.dot) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i] <= c_q[i] * norm_q[i];
      end
    end
    if (cmd_i.area) begin
      at_q   <= at_sat[pac3d_pkg::AccW-1:0];
      area_q <= area_sat[pac3d_pkg::AccW-1:0];
      sat_q  <= sat_q | at_sat[pac3d_pkg::AccW] | area_sat[pac3d_pkg::AccW];
    end
    if (cmd_i.wmul) begin
      for (int i = 0; i < 3; i++) begin
        lo_q[i] <= $signed({1'b0, at_q[31:0]}) * d_q[i];
        hi_q[i] <= $signed(at_q[pac3d_pkg::AccW-1:32]) * d_q[i];
      end
    end
    if (cmd_i.wacc) begin
      for (int i = 0; i < 3; i++) begin
        wsum_q[i] <= ws_sat[i][pac3d_pkg::AccW-1:0];
      end
      sat_q <= sat_q | ws_sat[0][pac3d_pkg::AccW] | ws_sat[1][pac3d_pkg::AccW] |
               ws_sat[2][pac3d_pkg::AccW];
    end
    if (cmd_i.fin) begin
      fclip_q <= 1'b0;
      axis_q  <= '0;
      bit_q   <= '0;
      rem_q   <= '0;
      dvs_q   <= {2'b00, abs_a} + {1'b0, abs_a, 1'b0};
      num_q   <= {mag(wsum_q[0]), {pac3d_pkg::DivShift{1'b0}}};
      for (int i = 0; i < 3; i++) begin
        ctr_q[i] <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (sts_o.div_done) begin
        // store this axis, then load the next one
        ctr_q[axis_q] <= c_clamp;
        fclip_q       <= fclip_q | !c_ok;
        axis_q        <= axis_q + 2'd1;
        bit_q         <= '0;
        rem_q         <= '0;
        num_q         <= {w_next_abs, {pac3d_pkg::DivShift{1'b0}}};
      end else begin
        bit_q <= bit_q + 1'b1;
        rem_q <= rem_d;
        num_q <= num_d;
      end
    end
    if (cmd_i.load_out) begin
      res_o.area             <= area_q;
      res_o.center_x         <= ctr_q[0];
      res_o.center_y         <= ctr_q[1];
      res_o.center_z         <= ctr_q[2];
      res_o.center_valid     <= sts_o.ctr_valid;
      res_o.too_few_vertices <= (cnt_q != pac3d_pkg::CntFull);
      res_o.saturated        <= sat_q | fclip_q;
    end
  end

  assign res_o.valid = out_valid_q;

endmodule

`default_nettype wire

### verif/tb_polygon_area_centroid_3d.sv
`timescale 1ns / 1ps

module tb_polygon_area_centroid_3d;

  typedef struct {
    pac3d_pkg::coord_t x, y, z;
    pac3d_pkg::norm_t  nx, ny, nz;
    logic   want, first, last;
  } vertex_word_t;

  typedef struct {
    pac3d_pkg::acc_t   area;
    pac3d_pkg::coord_t cx, cy, cz;
    logic   cvalid, few, sat;
  } area_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  pac3d_vtx_if vtx ();
  pac3d_res_if res ();

  polygon_area_centroid_3d dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vtx_i  (vtx.sink),
    .res_o  (res.source)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  vertex_word_t pending_vertices[$];
  area_word_t   expected_areas[$];
  int  failures = 0;
  int  cycle_count = 0;

  // Polygon state mirror
  logic signed [63:0] anchor_v[3], prev_v[3], normal_h[3], wsum[3];
  logic signed [63:0] area_acc;
  logic  want_h, sat_seen;
  int    vcount;

  function automatic logic signed [63:0] clip64(input logic signed [191:0] v, inout logic c);
    if (v > 192'sh7FFFFFFFFFFFFFFF) begin
      c = 1'b1;
      return 64'sh7FFFFFFFFFFFFFFF;
    end
    if (v < -192'sh8000000000000000) begin
      c = 1'b1;
      return 64'sh8000000000000000;
    end
    return v[63:0];
  endfunction

  task automatic predict_vertex(input vertex_word_t w);
    logic signed [63:0]  cur[3], a1[3], a2[3];
    logic signed [191:0] cr[3], dot, wt;
    logic signed [63:0]  tri_area, lim_hi, lim_lo;
    logic [191:0] mag_w, mag_a, q;
    logic signed [191:0] cv;
    logic clip, fclip, valid, few;
    area_word_t r;
    int i, j, k;
    clip = 1'b0;
    cur[0] = w.x; cur[1] = w.y; cur[2] = w.z;
    if (w.first || vcount == 0) begin
      for (i = 0; i < 3; i++) begin
        anchor_v[i] = cur[i];
        wsum[i] = 0;
      end
      normal_h[0] = w.nx; normal_h[1] = w.ny; normal_h[2] = w.nz;
      want_h = w.want;
      area_acc = 0;
      sat_seen = 1'b0;
      vcount = 0;
    end else if (vcount >= 2) begin
      for (i = 0; i < 3; i++) begin
        a1[i] = prev_v[i] - anchor_v[i];
        a2[i] = cur[i] - anchor_v[i];
      end
      for (i = 0; i < 3; i++) begin
        j = (i + 1) % 3;
        k = (i + 2) % 3;
        cr[i] = 192'(a1[j]) * 192'(a2[k]) - 192'(a1[k]) * 192'(a2[j]);
      end
      dot = 0;
      for (i = 0; i < 3; i++) dot = dot + cr[i] * 192'(normal_h[i]);
      dot = dot >>> pac3d_pkg::TriShift;
      tri_area = clip64(dot, clip);
      area_acc = clip64(192'(area_acc) + 192'(tri_area), clip);
      if (want_h) begin
        for (i = 0; i < 3; i++) begin
          wt = (192'(tri_area) * 192'(a1[i] + a2[i])) >>> 32;
          wsum[i] = clip64(192'(wsum[i]) + wt, clip);
        end
      end
    end
    for (i = 0; i < 3; i++) prev_v[i] = cur[i];
    if (vcount < 65535) vcount++;
    if (clip) sat_seen = 1'b1;
    if (!w.last) return;
    few = vcount < 3;
    valid = want_h && !few && area_acc != 0;
    fclip = 1'b0;
    lim_hi = 64'sh7FFFFFFF;
    lim_lo = -64'sh80000000;
    r.area = area_acc;
    for (i = 0; i < 3; i++) begin
      cv = 0;
      if (valid) begin
        mag_w = wsum[i] < 0 ? 192'(-192'(wsum[i])) : 192'(wsum[i]);
        mag_a = area_acc < 0 ? 192'(-192'(area_acc)) : 192'(area_acc);
        q = ((mag_w << 32) / mag_a) / 3;
        cv = ((wsum[i] < 0) != (area_acc < 0)) ? -$signed(q) : $signed(q);
        cv = 192'(clip64(192'(anchor_v[i]) + cv, fclip));
        if (cv > 192'(lim_hi)) begin
          cv = 192'(lim_hi);
          fclip = 1'b1;
        end else if (cv < 192'(lim_lo)) begin
          cv = 192'(lim_lo);
          fclip = 1'b1;
        end
      end
      if (i == 0) r.cx = cv[31:0];
      else if (i == 1) r.cy = cv[31:0];
      else r.cz = cv[31:0];
    end
    r.cvalid = valid;
    r.few = few;
    r.sat = sat_seen || fclip;
    vcount = 0;
    expected_areas.push_back(r);
  endtask

  function automatic pac3d_pkg::coord_t rand_coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return pac3d_pkg::coord_t'($signed($urandom_range(0, 2 ** 22)) - (2 ** 21));
      default: return pac3d_pkg::coord_t'($signed($urandom_range(0, 2 ** 17)) - (2 ** 16));
    endcase
  endfunction

  task automatic queue_vertex(input pac3d_pkg::coord_t x, y, z,
                              input pac3d_pkg::norm_t nx, ny, nz,
                              input logic want, first, last);
    vertex_word_t w;
    w.x = x; w.y = y; w.z = z;
    w.nx = nx; w.ny = ny; w.nz = nz;
    w.want = want; w.first = first; w.last = last;
    pending_vertices.push_back(w);
  endtask

  task automatic queue_polygon(input int n, input int mode, input logic want);
    pac3d_pkg::norm_t nx, ny, nz;
    int i;
    nx = pac3d_pkg::norm_t'($urandom());
    ny = pac3d_pkg::norm_t'($urandom());
    nz = pac3d_pkg::norm_t'($urandom());
    if ($urandom_range(0, 2) != 0) begin
      nx = 0; ny = 0; nz = 16384;
      if ($urandom_range(0, 1)) nz = -16384;
    end
    for (i = 0; i < n; i++)
      queue_vertex(rand_coord(mode), rand_coord(mode), rand_coord(mode), nx, ny, nz, want,
                   i == 0, i == n - 1);
  endtask

  // Driver: bursts with gaps
  vertex_word_t drive_word;
  int burst_left = 0, gap_left = 0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vtx.valid <= 1'b0;
    end else begin
      if (vtx.valid && vtx.ready) predict_vertex(drive_word);
      if (!vtx.valid || vtx.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          vtx.valid <= 1'b0;
        end else if (pending_vertices.size() > 0) begin
          drive_word = pending_vertices.pop_front();
          vtx.valid <= 1'b1;
          vtx.vertex_x <= drive_word.x;
          vtx.vertex_y <= drive_word.y;
          vtx.vertex_z <= drive_word.z;
          vtx.normal_x <= drive_word.nx;
          vtx.normal_y <= drive_word.ny;
          vtx.normal_z <= drive_word.nz;
          vtx.want_center <= drive_word.want;
          vtx.first_vertex <= drive_word.first;
          vtx.last_vertex <= drive_word.last;
          if (burst_left > 0) burst_left--;
          else begin
            burst_left = $urandom_range(0, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          vtx.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern plus one long hold-off
  int stall_phase = 0, holdoff_left = 0;
  bit holdoff_done = 1'b0;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res.ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (!holdoff_done && cycle_count == 3000) begin
        holdoff_left = 4000;
        holdoff_done = 1'b1;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        res.ready <= 1'b0;
      end else if ((stall_phase / 64) % 3 == 0) begin
        res.ready <= 1'b1;
      end else begin
        res.ready <= ($urandom_range(0, 2) != 0);
      end
    end
  end

  // Monitor
  always @(posedge clk_i) begin
    area_word_t e;
    if (rst_ni && res.valid && res.ready) begin
      if (expected_areas.size() == 0) begin
        $error("unexpected result word, area %h", res.area);
        failures++;
      end else begin
        e = expected_areas.pop_front();
        if (res.area !== e.area) begin
          $error("area exp %h got %h", e.area, res.area); failures++;
        end
        if (res.center_x !== e.cx) begin
          $error("center_x exp %h got %h", e.cx, res.center_x); failures++;
        end
        if (res.center_y !== e.cy) begin
          $error("center_y exp %h got %h", e.cy, res.center_y); failures++;
        end
        if (res.center_z !== e.cz) begin
          $error("center_z exp %h got %h", e.cz, res.center_z); failures++;
        end
        if (res.center_valid !== e.cvalid) begin
          $error("center_valid exp %b got %b", e.cvalid, res.center_valid); failures++;
        end
        if (res.too_few_vertices !== e.few) begin
          $error("too_few_vertices exp %b got %b", e.few, res.too_few_vertices); failures++;
        end
        if (res.saturated !== e.sat) begin
          $error("saturated exp %b got %b", e.sat, res.saturated); failures++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int i, n;
    vtx.valid = 1'b0;
    vtx.vertex_x = '0; vtx.vertex_y = '0; vtx.vertex_z = '0;
    vtx.normal_x = '0; vtx.normal_y = '0; vtx.normal_z = '0;
    vtx.want_center = 1'b0; vtx.first_vertex = 1'b0; vtx.last_vertex = 1'b0;
    res.ready = 1'b0;
    vcount = 0;
    want_h = 1'b0; sat_seen = 1'b0; area_acc = 0;
    for (i = 0; i < 3; i++) begin
      anchor_v[i] = 0; prev_v[i] = 0; normal_h[i] = 0; wsum[i] = 0;
    end

    // Vertex with no open polygon: first_vertex low still starts one
    queue_vertex(0, 0, 0, 0, 0, 16384, 1, 0, 0);
    queue_vertex(32'sh10000, 0, 0, 0, 0, 16384, 0, 0, 0);
    queue_vertex(0, 32'sh10000, 0, 0, 0, 16384, 0, 0, 1);
    // one vertex polygon, then two vertex polygon
    queue_vertex(5, 6, 7, 0, 0, 16384, 1, 1, 1);
    queue_vertex(5, 6, 7, 0, 0, 16384, 1, 1, 0);
    queue_vertex(9, 6, 7, 0, 0, 16384, 1, 0, 1);
    // dropped partial polygon, then extremes that saturate
    queue_vertex(1, 2, 3, 100, 200, 300, 1, 1, 0);
    queue_vertex(32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF, 32767, -32768, 32767, 1, 1, 0);
    queue_vertex(32'sh80000000, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    queue_vertex(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0, 0, 0, 0, 0, 0);
    queue_vertex(32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF, 0, 0, 0, 0, 0, 1);
    // zero area with centroid requested (collinear)
    queue_vertex(0, 0, 0, 0, 0, -16384, 1, 1, 0);
    queue_vertex(32'sh10000, 32'sh10000, 0, 0, 0, 0, 0, 0, 0);
    queue_vertex(32'sh20000, 32'sh20000, 0, 0, 0, 0, 0, 0, 1);
    // area without centroid, then full-range coordinates with centroid
    queue_polygon(4, 2, 1'b0);
    queue_polygon(5, 0, 1'b1);

    n = 0;
    while (n < 600) begin
      i = $urandom_range(0, 19);
      if (i == 0) begin
        // noise: stray vertex with random flags
        queue_vertex($urandom(), $urandom(), $urandom(), pac3d_pkg::norm_t'($urandom()),
                     pac3d_pkg::norm_t'($urandom()), pac3d_pkg::norm_t'($urandom()),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)));
        n++;
      end else begin
        i = (i < 3) ? $urandom_range(1, 2) : $urandom_range(3, 8);
        queue_polygon(i, ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 2),
                      $urandom_range(0, 3) != 0);
        n += i;
      end
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait (pending_vertices.size() == 0 && !vtx.valid);
    wait (expected_areas.size() == 0);
    repeat (1000) @(posedge clk_i);
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
